>>> src/bdbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdbm_pkg
// shared constants, types and popcount helpers for the descriptor matcher
// ----------------------------------------------------------------------------
package bdbm_pkg;

    localparam int DESC_WORDS  = 4;
    localparam int INDEX_RANGE = 4096;
    localparam int IN_WORDS    = 4;
    localparam int USED_WORDS  = (DESC_WORDS < IN_WORDS) ? DESC_WORDS : IN_WORDS;
    localparam int WORD_W      = 64;
    localparam int CNT_W       = 7;
    localparam int DIST_W      = 9;
    localparam int INDEX_W     = 12;
    localparam int SEEN_W      = 2;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int Q_DEPTH     = 2;
    localparam int IN_DATA_W   = ((2 * IN_WORDS * WORD_W + INDEX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((INDEX_W + 2 * DIST_W + 2 + 7) / 8) * 8;

    localparam logic [DIST_W-1:0] DIST_NONE   = 9'd256;
    localparam logic [DIST_W-1:0] LIMIT_RESET = 9'd50;
    localparam logic [DIST_W-1:0] RATIO_RESET = 9'd230;
    localparam logic [SEEN_W-1:0] SEEN_NONE   = 2'd0;
    localparam logic [SEEN_W-1:0] SEEN_ONE    = 2'd1;
    localparam logic [SEEN_W-1:0] SEEN_TWO    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISTANCE_LIMIT = 8'd0,
        CFG_RATIO_Q8       = 8'd1,
        CFG_RATIO_ENABLE   = 8'd2
    } t_cfg_reg;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [USED_WORDS-1:0][CNT_W-1:0] counts;
        logic [INDEX_W-1:0]               index;
        logic                             last;
    } t_cls;

    typedef struct packed {
        logic [DIST_W-1:0] limit;
        logic [DIST_W-1:0] ratio;
        logic              ratio_en;
    } t_cfg;

    function automatic logic [5:0] pop32(input logic [31:0] v);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = v - ((v >> 1) & 32'h5555_5555);
        b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
        c = (b + (b >> 4)) & 32'h0F0F_0F0F;
        return 6'(c[7:0] + c[15:8] + c[23:16] + c[31:24]);
    endfunction

    function automatic logic [CNT_W-1:0] pop64(input t_word w);
        return CNT_W'(pop32(w[31:0])) + CNT_W'(pop32(w[63:32]));
    endfunction

    function automatic logic [INDEX_W-1:0] wrap_index(input logic [INDEX_W-1:0] v);
        return INDEX_W'(32'(v) % INDEX_RANGE);
    endfunction

endpackage
`default_nettype wire

>>> src/bdbm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdbm_front
// xor and per-word popcount of query against candidate, one registered stage
// ----------------------------------------------------------------------------
module bdbm_front import bdbm_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire t_word [USED_WORDS-1:0]     i_query,
    input  wire t_word [USED_WORDS-1:0]     i_cand,
    input  wire logic [INDEX_W-1:0]         i_index,
    input  wire logic                       i_last,
    output logic                            o_valid,
    output t_cls                            o_item,
    input  wire logic                       i_ready
);

    logic r_valid;
    t_cls r_item;
    t_cls n_item;

    always_comb begin
        for (int w = 0; w < USED_WORDS; w++) begin
            n_item.counts[w] = pop64(i_query[w] ^ i_cand[w]);
        end
        n_item.index = wrap_index(i_index);
        n_item.last  = i_last;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

>>> src/bdbm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdbm_queue
// short queue between the popcount front and the running-best back
// ----------------------------------------------------------------------------
module bdbm_queue import bdbm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cls i_item,
    output logic      o_valid,
    output t_cls      o_item,
    input  wire logic i_ready
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);

    t_cls              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != CNT_QW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

>>> src/bdbm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdbm_back
// distance sum, running best and second, result stage and acceptance test
// ----------------------------------------------------------------------------
module bdbm_back import bdbm_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_cfg           i_cfg,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire t_cls           i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [INDEX_W-1:0]  o_best_index,
    output logic [DIST_W-1:0]   o_best_distance,
    output logic [DIST_W-1:0]   o_second_distance,
    output logic                o_has_second,
    output logic                o_accepted
);

    // running search state
    logic [DIST_W-1:0]  r_best;
    logic [DIST_W-1:0]  r_second;
    logic [INDEX_W-1:0] r_best_idx;
    logic [SEEN_W-1:0]  r_seen;
    logic [DIST_W-1:0]  n_best;
    logic [DIST_W-1:0]  n_second;
    logic [INDEX_W-1:0] n_best_idx;
    logic [SEEN_W-1:0]  n_seen;
    logic [DIST_W-1:0]  cand_dist;

    // finished search waiting for the acceptance test
    logic               r_a_valid;
    logic [INDEX_W-1:0] r_a_idx;
    logic [DIST_W-1:0]  r_a_best;
    logic [DIST_W-1:0]  r_a_second;
    logic               r_a_has2;

    // output register
    logic               r_o_valid;
    logic [INDEX_W-1:0] r_o_idx;
    logic [DIST_W-1:0]  r_o_best;
    logic [DIST_W-1:0]  r_o_second;
    logic               r_o_has2;
    logic               r_o_acc;

    logic               o_load;
    logic               a_ready;
    logic               pop;
    logic               has2;
    logic               n_acc;
    logic [17:0]        lhs;
    logic [17:0]        rhs;

    always_comb begin
        cand_dist = '0;
        for (int w = 0; w < USED_WORDS; w++) begin
            cand_dist = cand_dist + DIST_W'(i_item.counts[w]);
        end
    end

    always_comb begin
        n_best     = r_best;
        n_second   = r_second;
        n_best_idx = r_best_idx;
        n_seen     = r_seen;
        if (r_seen == SEEN_NONE) begin
            n_best     = cand_dist;
            n_best_idx = i_item.index;
        end else if (cand_dist < r_best) begin
            n_second   = r_best;
            n_best     = cand_dist;
            n_best_idx = i_item.index;
        end else if (r_seen == SEEN_ONE || cand_dist < r_second) begin
            n_second = cand_dist;
        end
        if (r_seen != SEEN_TWO) begin
            n_seen = r_seen + SEEN_ONE;
        end
    end

    assign has2    = (n_seen == SEEN_TWO);
    assign o_load  = !r_o_valid || i_ready;
    assign a_ready = !r_a_valid || o_load;
    assign o_ready = !i_item.last || a_ready;
    assign pop     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best     <= DIST_NONE;
            r_second   <= DIST_NONE;
            r_best_idx <= '0;
            r_seen     <= SEEN_NONE;
        end else if (pop) begin
            if (i_item.last) begin
                r_best     <= DIST_NONE;
                r_second   <= DIST_NONE;
                r_best_idx <= '0;
                r_seen     <= SEEN_NONE;
            end else begin
                r_best     <= n_best;
                r_second   <= n_second;
                r_best_idx <= n_best_idx;
                r_seen     <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= pop && i_item.last;
        end
        if (a_ready && pop && i_item.last) begin
            r_a_idx    <= n_best_idx;
            r_a_best   <= n_best;
            r_a_second <= has2 ? n_second : '0;
            r_a_has2   <= has2;
        end
    end

    // best*256 < ratio*second
    assign lhs = {1'b0, r_a_best, 8'd0};
    assign rhs = 18'(i_cfg.ratio) * 18'(r_a_second);

    always_comb begin
        n_acc = (r_a_best < i_cfg.limit);
        if (i_cfg.ratio_en && r_a_has2 && !(lhs < rhs)) begin
            n_acc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= r_a_valid;
        end
        if (o_load && r_a_valid) begin
            r_o_idx    <= r_a_idx;
            r_o_best   <= r_a_best;
            r_o_second <= r_a_second;
            r_o_has2   <= r_a_has2;
            r_o_acc    <= n_acc;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_best_index      = r_o_idx;
    assign o_best_distance   = r_o_best;
    assign o_second_distance = r_o_second;
    assign o_has_second      = r_o_has2;
    assign o_accepted        = r_o_acc;

endmodule
`default_nettype wire

>>> src/binary_descriptor_best_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_descriptor_best_match
// hamming nearest-neighbour search with distance limit and ratio test
// ----------------------------------------------------------------------------
// Takes one candidate item per clock while s_axis_tready is high: each item
// holds a 256-bit query and one 256-bit candidate descriptor, the candidate
// index and tlast for the final candidate of a search. The front stage
// registers one popcount per 64-bit word of query xor candidate, a two-entry
// queue decouples it from the back, which sums the counts and updates best,
// second and best index. On the tlast item one result is offered through a
// result stage (multiply for the ratio test) and the output register.
// Search state clears itself after every tlast item. Configuration writes are
// taken every cycle and should be made while no search is in flight.
// ----------------------------------------------------------------------------
module binary_descriptor_best_match import bdbm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // query_word0..3, cand_word0..3, cand_index, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // best_index, best_distance, second_distance, has_second, accepted
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    t_cfg               r_cfg;
    t_word [USED_WORDS-1:0] query;
    t_word [USED_WORDS-1:0] cand;
    logic               f_valid;
    logic               f_ready;
    t_cls               f_item;
    logic               q_valid;
    logic               q_ready;
    t_cls               q_item;
    logic [INDEX_W-1:0] best_index;
    logic [DIST_W-1:0]  best_distance;
    logic [DIST_W-1:0]  second_distance;
    logic               has_second;
    logic               accepted;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit    <= LIMIT_RESET;
            r_cfg.ratio    <= RATIO_RESET;
            r_cfg.ratio_en <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DISTANCE_LIMIT: begin
                    r_cfg.limit <= i_cfg_data;
                end
                CFG_RATIO_Q8: begin
                    r_cfg.ratio <= i_cfg_data;
                end
                CFG_RATIO_ENABLE: begin
                    r_cfg.ratio_en <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int w = 0; w < USED_WORDS; w++) begin
            query[w] = s_axis_tdata[w*WORD_W +: WORD_W];
            cand[w]  = s_axis_tdata[(IN_WORDS + w)*WORD_W +: WORD_W];
        end
    end

    bdbm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_query (query),
        .i_cand  (cand),
        .i_index (s_axis_tdata[2*IN_WORDS*WORD_W +: INDEX_W]),
        .i_last  (s_axis_tlast),
        .o_valid (f_valid),
        .o_item  (f_item),
        .i_ready (f_ready)
    );

    bdbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (q_ready)
    );

    bdbm_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (q_valid),
        .o_ready           (q_ready),
        .i_item            (q_item),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_best_index      (best_index),
        .o_best_distance   (best_distance),
        .o_second_distance (second_distance),
        .o_has_second      (has_second),
        .o_accepted        (accepted)
    );

    assign m_axis_tdata = OUT_DATA_W'({accepted, has_second, second_distance,
                                       best_distance, best_index});

endmodule
`default_nettype wire
